FILE: design/swrm_pkg.sv
`timescale 1ns / 1ps
package swrm_pkg;

  typedef struct packed {
    logic [63:0] sample_time_ns;
    logic [63:0] event_total;
    logic [63:0] byte_total;
  } sample_t;

  typedef struct packed {
    logic [63:0] span_ns;
    logic [63:0] span_events;
    logic [63:0] span_bytes;
    logic [63:0] events_per_sec;
    logic [63:0] bytes_per_sec;
    logic        rate_valid;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_CHECK,
    ST_NEWEST,
    ST_DIVIDE,
    ST_OUT
  } state_e;

  localparam logic [47:0] WindowReset = 48'd1000000000;
  localparam logic [29:0] NsPerSec    = 30'd1000000000;

endpackage

FILE: design/swrm_div.sv
`timescale 1ns / 1ps
// Scaled divider: floor(num * 1e9 / den), saturated, one quotient bit a cycle.
module swrm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [1:0]  phase_q, phase_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, lo_q, lo_d, q_q, q_d, den_q, den_d;
  logic [63:0] pl_q, pl_d, ph_q, ph_d;
  logic        done_q, done_d;
  logic [95:0] prod;
  logic [64:0] shifted;

  assign prod    = {32'd0, pl_q} + {ph_q, 32'd0};
  assign shifted = {rem_q, lo_q[63]};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    q_d     = q_q;
    den_d   = den_q;
    pl_d    = pl_q;
    ph_d    = ph_q;
    done_d  = 1'b0;
    case (phase_q)
      2'd0: begin
        if (start_i) begin
          pl_d    = {32'd0, num_i[31:0]} * {34'd0, swrm_pkg::NsPerSec};
          ph_d    = {32'd0, num_i[63:32]} * {34'd0, swrm_pkg::NsPerSec};
          den_d   = den_i;
          phase_d = 2'd1;
        end
      end
      2'd1: begin
        rem_d = {32'd0, prod[95:64]};
        lo_d  = prod[63:0];
        q_d   = '0;
        cnt_d = 7'd64;
        if (den_q == 64'd0) begin
          q_d = '0;
          phase_d = 2'd0;
          done_d  = 1'b1;
        end else if ({32'd0, prod[95:64]} >= den_q) begin
          q_d = '1;
          phase_d = 2'd0;
          done_d  = 1'b1;
        end else begin
          phase_d = 2'd2;
        end
      end
      default: begin
        lo_d = {lo_q[62:0], 1'b0};
        if (shifted >= {1'b0, den_q}) begin
          rem_d = 64'(shifted - {1'b0, den_q});
          q_d   = {q_q[62:0], 1'b1};
        end else begin
          rem_d = shifted[63:0];
          q_d   = {q_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          phase_d = 2'd0;
          done_d  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    q_q   <= q_d;
    den_q <= den_d;
    pl_q  <= pl_d;
    ph_q  <= ph_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

FILE: design/sliding_window_rate_meter.sv
`timescale 1ns / 1ps
// A request passes through the write, the eviction walk (a read and a check per examined entry),
// the two scaled divisions on the shared bit-serial divider, and then the output register.
// Throughput: one request at a time; a new request is taken once the previous one has left the
// walk and the divider, and a stalled result only holds the next one in its final state.
// The eviction walk reads the ring one entry at a time; the divisions are skipped when the span is
// not positive. Reset clears pointers, count, window length and state; the ring is not cleared.
module sliding_window_rate_meter #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [47:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swrm_pkg::sample_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swrm_pkg::result_t   out_data_o
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW:0] DepthW = (AW + 1)'(HISTORY_DEPTH);

  // The ring is one memory holding time, events and bytes per entry.
  logic [191:0] ring_mem [HISTORY_DEPTH];
  logic [191:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  swrm_pkg::state_e state_q, state_d;
  logic [47:0]   window_q;
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] kept_q, kept_d;
  swrm_pkg::sample_t smp_q;
  logic [63:0]   floor_q;
  logic [191:0]  old_q, old_d;
  logic          which_q, which_d;
  logic          div_start;
  logic          div_done;
  logic [63:0]   div_quot;
  logic [63:0]   dt, de, db;
  logic [63:0]   eps_q, eps_d;
  swrm_pkg::result_t res_q, res_d;
  logic          ov_q, ov_d;
  logic [AW:0]   oldest_sum;
  logic [AW-1:0] oldest;

  // Oldest kept slot: write pointer minus kept count, wrapped to the ring depth.
  assign oldest_sum = ({1'b0, wp_q} + DepthW - (AW + 1)'(kept_q));
  assign oldest     = (oldest_sum >= DepthW) ? AW'(oldest_sum - DepthW) : oldest_sum[AW-1:0];

  assign dt = smp_q.sample_time_ns - old_q[191:128];
  assign de = smp_q.event_total - old_q[127:64];
  assign db = smp_q.byte_total - old_q[63:0];

  // The result register parts the two sides: a new request may enter while a result waits.
  assign in_ready_o = (state_q == swrm_pkg::ST_IDLE);
  assign rd_addr    = oldest;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swrm_pkg::ST_IDLE:   if (in_valid_i) state_d = swrm_pkg::ST_WRITE;
      swrm_pkg::ST_WRITE:  state_d = swrm_pkg::ST_READ;
      swrm_pkg::ST_READ:   state_d = swrm_pkg::ST_CHECK;
      swrm_pkg::ST_CHECK: begin
        if (kept_q > CW'(1) && rd_data_q[191:128] < floor_q) begin
          state_d = swrm_pkg::ST_READ;
        end else begin
          state_d = swrm_pkg::ST_NEWEST;
        end
      end
      swrm_pkg::ST_NEWEST: begin
        if (smp_q.sample_time_ns <= old_q[191:128]) state_d = swrm_pkg::ST_OUT;
        else state_d = swrm_pkg::ST_DIVIDE;
      end
      swrm_pkg::ST_DIVIDE: if (div_done && which_q) state_d = swrm_pkg::ST_OUT;
      // Wait here until the result register is free or is being emptied.
      swrm_pkg::ST_OUT:    if (!ov_q || out_ready_i) state_d = swrm_pkg::ST_IDLE;
      default:             state_d = swrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wp_d      = wp_q;
    kept_d    = kept_q;
    old_d     = old_q;
    which_d   = which_q;
    eps_d     = eps_q;
    res_d     = res_q;
    ov_d      = ov_q;
    rd_en     = 1'b0;
    div_start = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      swrm_pkg::ST_WRITE: begin
        wp_d = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        if (kept_q < CW'(HISTORY_DEPTH)) kept_d = kept_q + CW'(1);
      end
      swrm_pkg::ST_READ: rd_en = 1'b1;
      swrm_pkg::ST_CHECK: begin
        old_d = rd_data_q;
        if (kept_q > CW'(1) && rd_data_q[191:128] < floor_q) kept_d = kept_q - CW'(1);
      end
      swrm_pkg::ST_NEWEST: begin
        which_d   = 1'b0;
        div_start = smp_q.sample_time_ns > old_q[191:128];
      end
      swrm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          if (!which_q) begin
            eps_d     = div_quot;
            which_d   = 1'b1;
            div_start = 1'b1;
          end
        end
      end
      swrm_pkg::ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          if (smp_q.sample_time_ns > old_q[191:128]) begin
            res_d = '{span_ns: dt, span_events: de, span_bytes: db,
                      events_per_sec: eps_q, bytes_per_sec: div_quot, rate_valid: 1'b1};
          end else begin
            res_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  swrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (which_d ? db : de),
    .den_i   (dt),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == swrm_pkg::ST_WRITE) ring_mem[wp_q] <= smp_q;
    if (rd_en) rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == swrm_pkg::ST_IDLE) begin
      smp_q   <= in_data_i;
      floor_q <= (in_data_i.sample_time_ns > {16'd0, window_q})
               ? in_data_i.sample_time_ns - {16'd0, window_q} : 64'd0;
    end
    old_q <= old_d;
    eps_q <= eps_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swrm_pkg::ST_IDLE;
      window_q <= swrm_pkg::WindowReset;
      wp_q     <= '0;
      kept_q   <= '0;
      which_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
      wp_q    <= wp_d;
      kept_q  <= kept_d;
      which_q <= which_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

endmodule

FILE: design/swrm_checker.sv
`timescale 1ns / 1ps
module swrm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input swrm_pkg::result_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.rate_valid |-> out_data_o.span_ns == 64'd0)
    else $error("invalid result not zero");

  a_valid_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rate_valid |-> out_data_o.span_ns != 64'd0)
    else $error("valid result with zero span");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back to back accept");

endmodule

bind sliding_window_rate_meter swrm_checker u_swrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: test/sliding_window_rate_meter_tb.sv
`timescale 1ns / 1ps
module sliding_window_rate_meter_tb;

  localparam int Depth = 64;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] WindowMax = 48'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [47:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  swrm_pkg::sample_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  swrm_pkg::result_t out_data_o;

  sliding_window_rate_meter #(.HISTORY_DEPTH(Depth)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the block's history ring and window register.
  logic [63:0] hist_time [Depth];
  logic [63:0] hist_events [Depth];
  logic [63:0] hist_bytes [Depth];
  int unsigned wr_slot;
  int unsigned kept;
  logic [47:0] window_ns;

  swrm_pkg::result_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int stall_left = 0;
  bit quiet = 1'b0;   // When set, neither side idles.

  // Floor of num * 1e9 / den, saturated when the quotient needs more than 64 bits.
  function automatic logic [63:0] per_second(logic [63:0] num, logic [63:0] den);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, num} * 128'd1000000000;
    if (den == 64'd0) return 64'd0;
    quo = prod / {64'd0, den};
    if (quo[127:64] != 64'd0) return AllOnes;
    return quo[63:0];
  endfunction

  // Insert the sample, trim the window, and return the result it causes.
  function automatic swrm_pkg::result_t window_result(swrm_pkg::sample_t s);
    swrm_pkg::result_t r;
    logic [63:0] floor_t;
    int unsigned newest, oldest;
    hist_time[wr_slot] = s.sample_time_ns;
    hist_events[wr_slot] = s.event_total;
    hist_bytes[wr_slot] = s.byte_total;
    wr_slot = (wr_slot + 1) % Depth;
    if (kept < Depth) kept++;
    floor_t = (s.sample_time_ns > {16'd0, window_ns}) ?
              s.sample_time_ns - {16'd0, window_ns} : 64'd0;
    while (kept > 1 && hist_time[(wr_slot + Depth - kept) % Depth] < floor_t) kept--;
    r = '0;
    newest = (wr_slot + Depth - 1) % Depth;
    oldest = (wr_slot + Depth - kept) % Depth;
    if (hist_time[newest] > hist_time[oldest]) begin
      r.span_ns = hist_time[newest] - hist_time[oldest];
      r.span_events = hist_events[newest] - hist_events[oldest];
      r.span_bytes = hist_bytes[newest] - hist_bytes[oldest];
      r.events_per_sec = per_second(r.span_events, r.span_ns);
      r.bytes_per_sec = per_second(r.span_bytes, r.span_ns);
      r.rate_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  // Send one request; the expectation is queued at the edge that accepts it.
  task automatic send_sample(logic [63:0] t, logic [63:0] ev, logic [63:0] by);
    swrm_pkg::sample_t s;
    int gap;
    s.sample_time_ns = t;
    s.event_total = ev;
    s.byte_total = by;
    // Step to a fresh falling edge so valid is never driven twice in one step.
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(window_result(s));
    requests_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Receiver side: random stall bursts on ready.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      stall_left <= 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    swrm_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result %0d with nothing pending", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.span_ns !== want.span_ns)
          report_mismatch("span_ns", out_data_o.span_ns, want.span_ns);
        if (out_data_o.span_events !== want.span_events)
          report_mismatch("span_events", out_data_o.span_events, want.span_events);
        if (out_data_o.span_bytes !== want.span_bytes)
          report_mismatch("span_bytes", out_data_o.span_bytes, want.span_bytes);
        if (out_data_o.events_per_sec !== want.events_per_sec)
          report_mismatch("events_per_sec", out_data_o.events_per_sec, want.events_per_sec);
        if (out_data_o.bytes_per_sec !== want.bytes_per_sec)
          report_mismatch("bytes_per_sec", out_data_o.bytes_per_sec, want.bytes_per_sec);
        if (out_data_o.rate_valid !== want.rate_valid)
          report_mismatch("rate_valid", {63'd0, out_data_o.rate_valid},
                          {63'd0, want.rate_valid});
      end
    end
  end

  // Wait until every pending result has come back, then let the block settle.
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Window writes happen only while the block is idle.
  task automatic set_window(logic [47:0] w);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    window_ns = w;
  endtask

  task automatic test_directed_extremes();
    // Invalid span: first sample alone, then an equal timestamp.
    send_sample(64'd0, 64'd0, 64'd0);
    send_sample(64'd0, AllOnes, AllOnes);
    // A tiny span that saturates the rate.
    send_sample(64'd1, 64'd5, 64'd3);
    send_sample(64'd2, AllOnes, AllOnes);
    // A timestamp going backward still measures from the oldest kept sample.
    send_sample(64'd1, 64'd9, 64'd9);
    send_sample(64'd500_000_000, 64'd1000, 64'd2000);
    send_sample(64'd2_500_000_000, 64'd1_000_000, 64'd7);
    // Top of the time range with the largest window; the totals wrap between these samples.
    set_window(WindowMax);
    send_sample(AllOnes - 64'd1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_sample(AllOnes, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_zero_window();
    // A zero window keeps only entries no older than the newest one, so spans go invalid.
    set_window(48'd0);
    send_sample(64'd100, 64'd1, 64'd1);
    send_sample(64'd200, 64'd2, 64'd2);
    send_sample(64'd200, 64'd3, 64'd3);
    set_window(48'd1);
    send_sample(64'd201, 64'd4, 64'd4);
    send_sample(64'd203, 64'd8, 64'd8);
  endtask

  task automatic test_ring_full();
    int i;
    // Large window: the ring fills and starts evicting its oldest entry.
    set_window(WindowMax);
    for (i = 0; i < Depth + 8; i++)
      send_sample(64'd10_000 + 64'(i) * 64'd1000, 64'(i) * 64'd3, 64'(i) * 64'd100);
  endtask

  // Random walks of rising timestamps, with occasional noise.
  task automatic test_random(int count);
    logic [63:0] t, ev, by;
    int i;
    t = {$urandom, $urandom};
    ev = {$urandom, $urandom};
    by = {$urandom, $urandom};
    for (i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: set_window(48'($urandom_range(1, 5000)));
          1: set_window(48'({$urandom, $urandom}));
          2: set_window(48'd1);
          default: set_window(WindowMax);
        endcase
        t = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : 64'($urandom);
      end
      case ($urandom_range(0, 9))
        0: begin
          t = {$urandom, $urandom};
          ev = {$urandom, $urandom};
          by = {$urandom, $urandom};
        end
        1: ;   // Repeat the timestamp.
        default: begin
          t = t + 64'($urandom_range(0, 3000));
          ev = ev + 64'($urandom_range(0, 100_000));
          by = by + {32'd0, $urandom};
        end
      endcase
      send_sample(t, ev, by);
      if (i == count / 2) drain();   // Sender holds off until the block is empty.
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < Depth; i++) begin
      hist_time[i] = '0;
      hist_events[i] = '0;
      hist_bytes[i] = '0;
    end
    wr_slot = 0;
    kept = 0;
    window_ns = swrm_pkg::WindowReset;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_zero_window();
    test_ring_full();
    test_random(320);
    drain();
    quiet = 1'b1;
    test_random(40);
    drain();
    repeat (200) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d results across several window settings,",
             requests_sent, results_seen);
    $display("covering invalid spans, wrapped totals, saturated rates and ring eviction.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sliding_window_rate_meter_tb: PASS");
    end else begin
      $display("sliding_window_rate_meter_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results pending", pending_results.size());
    $display("sliding_window_rate_meter_tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/swrm_pkg.sv
design/swrm_div.sv
design/sliding_window_rate_meter.sv
design/swrm_checker.sv
test/sliding_window_rate_meter_tb.sv
